// ===== src/i2dcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dcf_pkg: shared types and constants of the 2-D correlation filter
// Kernel geometry, field widths, register indexes and pipeline structs.
// ----------------------------------------------------------------------------
package i2dcf_pkg;

    // Geometry
    localparam int KS        = 3;
    localparam int MAX_WIDTH = 1024;
    localparam int COEF_BITS = 12;
    localparam int FRAC_BITS = 8;
    localparam int LINES     = KS - 1;
    localparam int HALF      = (KS - 1) / 2;

    // Field widths
    localparam int CH_W      = 8;
    localparam int NCH       = 3;
    localparam int PIX_W     = NCH * CH_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 11;
    localparam int ROW_W     = 11;
    localparam int POS_W     = 10;
    localparam int SLOT_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CFG_W     = 60;
    localparam int NROWS     = 5;
    localparam int IDX_W     = 3;
    localparam int DELTA_W   = 9;
    localparam int PROD_W    = COEF_BITS + CH_W + 1;
    localparam int SUM_W     = PROD_W + $clog2(KS * KS);
    localparam int PIX_MAX   = 255;

    localparam logic [DIM_W-1:0] DIM_RST = 11'd1024;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_COEF0  = 3'd0,
        REG_COEF1  = 3'd1,
        REG_COEF2  = 3'd2,
        REG_COEF3  = 3'd3,
        REG_COEF4  = 3'd4,
        REG_DELTA  = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [KS-1:0][KS-1:0] win_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [KS-1:0][KS-1:0] kern_t;
    typedef logic [NCH-1:0][CH_W-1:0] res_t;

    // Per-item side information that travels down the pipeline
    typedef struct packed {
        logic             prod;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } meta_t;

    // Load strobes of the arithmetic stages
    typedef struct packed {
        logic prod_en;
        logic sum_en;
        logic out_en;
    } mac_ctl_t;

endpackage

// ===== src/i2dcf_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dcf_line_ram: single-port line buffer memory
// Registered read; a read and a write at one address return the old data.
// ----------------------------------------------------------------------------
module i2dcf_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read old contents, write new pixel
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== src/i2dcf_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2dcf_mac: kernel multiply, sum, round toward zero, offset and clamp
// Three register stages: products, channel sums, clamped results.
// ----------------------------------------------------------------------------
module i2dcf_mac (
    input  logic                                 aclk,
    input  i2dcf_pkg::mac_ctl_t                  ctl,
    input  i2dcf_pkg::win_t                      win,
    input  i2dcf_pkg::kern_t                     kern,
    input  logic signed [i2dcf_pkg::DELTA_W-1:0] delta,
    output i2dcf_pkg::res_t                      res
);

    localparam int KS     = i2dcf_pkg::KS;
    localparam int NCH    = i2dcf_pkg::NCH;
    localparam int CH_W   = i2dcf_pkg::CH_W;
    localparam int PROD_W = i2dcf_pkg::PROD_W;
    localparam int SUM_W  = i2dcf_pkg::SUM_W;

    logic signed [PROD_W-1:0] prod_reg [NCH][KS][KS];
    logic signed [SUM_W-1:0]  sum_reg  [NCH];
    logic signed [SUM_W-1:0]  sum_next [NCH];
    i2dcf_pkg::res_t          res_reg;
    i2dcf_pkg::res_t          res_next;

    // Multiply each tap by its coefficient
    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            for (int ch = 0; ch < NCH; ch++) begin
                for (int i = 0; i < KS; i++) begin
                    for (int j = 0; j < KS; j++) begin
                        prod_reg[ch][i][j] <= kern[i][j] *
                            $signed({1'b0, win[i][j][ch*CH_W +: CH_W]});
                    end
                end
            end
        end
    end

    // Sum the taps of each channel
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            sum_next[ch] = '0;
            for (int i = 0; i < KS; i++) begin
                for (int j = 0; j < KS; j++) begin
                    sum_next[ch] = sum_next[ch] + SUM_W'(prod_reg[ch][i][j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            sum_reg <= sum_next;
        end
    end

    // Drop fraction toward zero, add offset, clamp to pixel range
    always_comb begin
        logic signed [SUM_W:0]   ext;
        logic signed [SUM_W:0]   mag;
        logic signed [SUM_W:0]   q;
        logic signed [SUM_W+1:0] r;
        for (int ch = 0; ch < NCH; ch++) begin
            ext = (SUM_W+1)'(sum_reg[ch]);
            mag = ext[SUM_W] ? -ext : ext;
            q   = mag >>> i2dcf_pkg::FRAC_BITS;
            if (ext[SUM_W]) begin
                q = -q;
            end
            r = (SUM_W+2)'(q) + (SUM_W+2)'(delta);
            if (r < 0) begin
                res_next[ch] = '0;
            end else if (r > i2dcf_pkg::PIX_MAX) begin
                res_next[ch] = CH_W'(i2dcf_pkg::PIX_MAX);
            end else begin
                res_next[ch] = r[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== src/image_2d_correlation_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_2d_correlation_filter: 3x3 correlation filter on RGB pixels
// Line buffers feed a sliding window; each channel is correlated with a
// signed Q4.8 kernel, offset and clamped. Only interior pixels give results.
// ----------------------------------------------------------------------------
//  Channel  Ports                                   Direction  Handshake
//  input    s_frame_start, s_pix_ch0..2             in         s_valid/s_ready
//  result   m_res_ch0..2, m_out_row/col,            out        m_valid/m_ready
//           m_frame_last
//  config   cfg_wen, cfg_index, cfg_wdata           in         write enable
//
//  One item per clock sustained while results are taken; m_valid rises after
//  the line buffer read with stage 1, then window, products, sums and clamp.
//  Throughput is set by the single-port line buffers: one read and one
//  write per item in the accept cycle.
//  Reset (aresetn, synchronous) clears counters, configuration registers and pipe valids;
//  line buffers and window are not cleared.
//  A stalled result holds its stage; upstream stages keep filling bubbles.
// ----------------------------------------------------------------------------
module image_2d_correlation_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_frame_start,
    input  logic [i2dcf_pkg::CH_W-1:0]          s_pix_ch0,
    input  logic [i2dcf_pkg::CH_W-1:0]          s_pix_ch1,
    input  logic [i2dcf_pkg::CH_W-1:0]          s_pix_ch2,
    // Result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [i2dcf_pkg::CH_W-1:0]          m_res_ch0,
    output logic [i2dcf_pkg::CH_W-1:0]          m_res_ch1,
    output logic [i2dcf_pkg::CH_W-1:0]          m_res_ch2,
    output logic [i2dcf_pkg::POS_W-1:0]         m_out_row,
    output logic [i2dcf_pkg::POS_W-1:0]         m_out_col,
    output logic                                m_frame_last,
    // Configuration
    input  logic                                cfg_wen,
    input  logic [i2dcf_pkg::IDX_W-1:0]         cfg_index,
    input  logic [i2dcf_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int KS     = i2dcf_pkg::KS;
    localparam int LINES  = i2dcf_pkg::LINES;
    localparam int COL_W  = i2dcf_pkg::COL_W;
    localparam int ROW_W  = i2dcf_pkg::ROW_W;
    localparam int DIM_W  = i2dcf_pkg::DIM_W;
    localparam int POS_W  = i2dcf_pkg::POS_W;
    localparam int SLOT_W = i2dcf_pkg::SLOT_W;
    localparam int CB     = i2dcf_pkg::COEF_BITS;

    // Configuration registers
    logic [i2dcf_pkg::CFG_W-1:0]         coef_reg [i2dcf_pkg::NROWS];
    logic signed [i2dcf_pkg::DELTA_W-1:0] delta_reg;
    logic [DIM_W-1:0]                    width_reg;
    logic [DIM_W-1:0]                    height_reg;

    // Position counters
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // Pipeline
    logic en1, en2, en3, en4, en_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    i2dcf_pkg::meta_t meta0, meta1_reg, meta2_reg, meta3_reg, meta4_reg, metao_reg;
    i2dcf_pkg::pix_t  pix0, pix1_reg;
    logic [SLOT_W-1:0] slot1_reg;
    i2dcf_pkg::pix_t  rd_data [LINES];
    i2dcf_pkg::pix_t  col1 [KS];
    i2dcf_pkg::win_t  win_reg;
    i2dcf_pkg::kern_t kern;
    i2dcf_pkg::res_t  res;
    i2dcf_pkg::mac_ctl_t mac_ctl;
    logic [LINES-1:0] wr_vec;
    logic             accept;

    // Current position of this item
    logic [COL_W:0]   w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [SLOT_W-1:0] s0;
    logic [COL_W:0]   c_inc;
    logic [ROW_W:0]   r_inc;

    assign accept = s_valid & s_ready;
    assign pix0   = {s_pix_ch2, s_pix_ch1, s_pix_ch0};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < i2dcf_pkg::NROWS; i++) begin
                coef_reg[i] <= '0;
            end
            delta_reg  <= '0;
            width_reg  <= i2dcf_pkg::DIM_RST;
            height_reg <= i2dcf_pkg::DIM_RST;
        end else if (cfg_wen) begin
            case (i2dcf_pkg::cfg_reg_t'(cfg_index))
                i2dcf_pkg::REG_COEF0:  coef_reg[0] <= cfg_wdata;
                i2dcf_pkg::REG_COEF1:  coef_reg[1] <= cfg_wdata;
                i2dcf_pkg::REG_COEF2:  coef_reg[2] <= cfg_wdata;
                i2dcf_pkg::REG_COEF3:  coef_reg[3] <= cfg_wdata;
                i2dcf_pkg::REG_COEF4:  coef_reg[4] <= cfg_wdata;
                i2dcf_pkg::REG_DELTA:  delta_reg  <= cfg_wdata[i2dcf_pkg::DELTA_W-1:0];
                i2dcf_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                i2dcf_pkg::REG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack kernel taps
    always_comb begin
        for (int i = 0; i < KS; i++) begin
            for (int j = 0; j < KS; j++) begin
                kern[i][j] = coef_reg[i][CB*j +: CB];
            end
        end
    end

    // Resolve position, result flag and next counters
    always_comb begin
        if (width_reg == '0) begin
            w_eff = (COL_W+1)'(1);
        end else if (int'(width_reg) > i2dcf_pkg::MAX_WIDTH) begin
            w_eff = (COL_W+1)'(i2dcf_pkg::MAX_WIDTH);
        end else begin
            w_eff = (COL_W+1)'(width_reg);
        end
        h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;

        c0 = s_frame_start ? '0 : col_reg;
        r0 = s_frame_start ? '0 : row_reg;
        s0 = s_frame_start ? '0 : slot_reg;
        if ({1'b0, c0} >= w_eff) begin
            c0 = '0;
        end
        if (r0 >= h_eff) begin
            r0 = '0;
            s0 = '0;
        end

        meta0.prod = (int'(r0) >= KS - 1) && (int'(c0) >= KS - 1);
        meta0.row  = POS_W'(r0 - ROW_W'(i2dcf_pkg::HALF));
        meta0.col  = POS_W'(c0 - COL_W'(i2dcf_pkg::HALF));
        meta0.last = (r0 == h_eff - DIM_W'(1)) && ({1'b0, c0} == w_eff - (COL_W+1)'(1));

        c_inc = {1'b0, c0} + (COL_W+1)'(1);
        r_inc = {1'b0, r0} + (ROW_W+1)'(1);
        row_next  = r0;
        slot_next = s0;
        col_next  = c_inc[COL_W-1:0];
        if (c_inc >= w_eff) begin
            col_next = '0;
            if (r_inc >= {1'b0, h_eff}) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = r_inc[ROW_W-1:0];
                slot_next = (int'(s0) == LINES - 1) ? '0 : s0 + SLOT_W'(1);
            end
        end
    end

    // Advance counters per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end else if (accept) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

    // Line buffers: read all rows at this column, write the new pixel
    for (genvar k = 0; k < LINES; k++) begin : g_line
        assign wr_vec[k] = (int'(s0) == k);
        i2dcf_line_ram #(
            .DEPTH (i2dcf_pkg::MAX_WIDTH),
            .WIDTH (i2dcf_pkg::PIX_W)
        ) u_ram (
            .aclk  (aclk),
            .en    (accept),
            .we    (wr_vec[k]),
            .addr  (c0),
            .wdata (pix0),
            .rdata (rd_data[k])
        );
    end

    // Stage enables: a stage loads when empty or when it drains
    assign en_out = ~vo_reg | m_ready;
    assign en4    = ~v4_reg | en_out;
    assign en3    = ~v3_reg | en4;
    assign en2    = ~v2_reg | en3;
    assign en1    = ~v1_reg | en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg <= s_valid;
            if (en2)    v2_reg <= v1_reg;
            if (en3)    v3_reg <= v2_reg;
            if (en4)    v4_reg <= v3_reg;
            if (en_out) vo_reg <= v4_reg & meta4_reg.prod;
        end
    end

    // Stage 1: hold pixel and position while line data is read
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg  <= pix0;
            slot1_reg <= s0;
            meta1_reg <= meta0;
        end
    end

    // Order line buffer outputs into window rows
    always_comb begin
        int idx;
        for (int i = 0; i < LINES; i++) begin
            idx = int'(slot1_reg) + 1 + i;
            if (idx >= LINES) begin
                idx = idx - LINES;
            end
            col1[i] = rd_data[SLOT_W'(idx)];
        end
        col1[KS-1] = pix1_reg;
    end

    // Stage 2: shift the window by one column
    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            for (int i = 0; i < KS; i++) begin
                for (int j = 0; j < KS - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][KS-1] <= col1[i];
            end
            meta2_reg <= meta1_reg;
        end
    end

    // Stages 3 to result: side information follows the arithmetic
    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) meta3_reg <= meta2_reg;
        if (en4 && v3_reg) meta4_reg <= meta3_reg;
        if (en_out && v4_reg) metao_reg <= meta4_reg;
    end

    assign mac_ctl.prod_en = en3 & v2_reg;
    assign mac_ctl.sum_en  = en4 & v3_reg;
    assign mac_ctl.out_en  = en_out & v4_reg;

    i2dcf_mac u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .win   (win_reg),
        .kern  (kern),
        .delta (delta_reg),
        .res   (res)
    );

    assign m_valid      = vo_reg;
    assign m_res_ch0    = res[0];
    assign m_res_ch1    = res[1];
    assign m_res_ch2    = res[2];
    assign m_out_row    = metao_reg.row;
    assign m_out_col    = metao_reg.col;
    assign m_frame_last = metao_reg.last;

    // Input stalls only when every stage is full and the result waits
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked result");

    // Each item writes exactly one line buffer
    a_one_line: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> $onehot(wr_vec))
        else $error("line buffer write select not one-hot");

    // A result appears only behind an interior item
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (en_out && !(v4_reg && meta4_reg.prod)) |=> !m_valid)
        else $error("result without an interior item");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 RGB correlation filter
// Frames of random and patterned pixels are streamed through the input channel. A local
// model of the line buffers, window and kernel predicts every interior
// result, which is checked field by field against the result channel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CH_W      = i2dcf_pkg::CH_W;
    localparam int POS_W     = i2dcf_pkg::POS_W;
    localparam int IDX_W     = i2dcf_pkg::IDX_W;
    localparam int CFG_W     = i2dcf_pkg::CFG_W;
    localparam int NROWS     = i2dcf_pkg::NROWS;
    localparam int DELTA_W   = i2dcf_pkg::DELTA_W;
    localparam int DIM_W     = i2dcf_pkg::DIM_W;
    localparam int LINES     = i2dcf_pkg::LINES;
    localparam int MAX_WIDTH = i2dcf_pkg::MAX_WIDTH;
    localparam int KS        = i2dcf_pkg::KS;
    localparam int COEF_BITS = i2dcf_pkg::COEF_BITS;
    localparam int FRAC_BITS = i2dcf_pkg::FRAC_BITS;
    localparam int PIX_MAX   = i2dcf_pkg::PIX_MAX;
    localparam int HALF      = i2dcf_pkg::HALF;
    localparam logic [DIM_W-1:0] DIM_RST = i2dcf_pkg::DIM_RST;

    localparam int RUN_LIMIT  = 1000000;
    localparam int DRAIN_CYC  = 20;
    localparam int RAND_ITEMS = 700;

    typedef struct {
        logic            fs;
        logic [CH_W-1:0] c0, c1, c2;
    } pixel_t;

    typedef struct {
        logic [CH_W-1:0]  r0, r1, r2;
        logic [POS_W-1:0] row, col;
        logic             last;
    } filt_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_frame_start = 1'b0;
    logic [CH_W-1:0] s_pix_ch0 = '0, s_pix_ch1 = '0, s_pix_ch2 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CH_W-1:0] m_res_ch0, m_res_ch1, m_res_ch2;
    logic [POS_W-1:0] m_out_row, m_out_col;
    logic m_frame_last;
    logic cfg_wen = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    image_2d_correlation_filter uut (.*);

    // Clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Pixels waiting to be sent, results waiting to arrive
    pixel_t    pixel_q[$];
    filt_res_t result_q[$];

    // Model state: mirror of the registers plus line buffers and window
    logic [CFG_W-1:0]     kern_rows[NROWS];
    logic [DELTA_W-1:0]   delta_reg;
    logic [DIM_W-1:0]     width_reg, height_reg;
    i2dcf_pkg::pix_t      line_mem[LINES*MAX_WIDTH];
    i2dcf_pkg::pix_t      win_m[KS][KS];
    int unsigned          row_cnt, col_cnt;

    int  n_accepted = 0;
    int  n_errors = 0;
    int  cyc = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    int  src_gap = 0;
    int  snk_gap = 0;

    // One channel of the window through the kernel, truncated, offset, clamped
    function automatic logic [CH_W-1:0] channel_value(input int ch);
        longint acc, q, r;
        i2dcf_pkg::coef_t k;
        acc = 0;
        for (int i = 0; i < KS; i++)
            for (int j = 0; j < KS; j++) begin
                k = kern_rows[i][COEF_BITS*j +: COEF_BITS];
                acc += longint'(k) * longint'({56'd0, win_m[i][j][CH_W*ch +: CH_W]});
            end
        if (acc < 0)
            q = -((-acc) >>> FRAC_BITS);
        else
            q = acc >>> FRAC_BITS;
        r = q + longint'($signed(delta_reg));
        if (r < 0)
            r = 0;
        if (r > PIX_MAX)
            r = PIX_MAX;
        return r[CH_W-1:0];
    endfunction

    // Advance the model by one accepted pixel and queue its result, if any
    task automatic filter_pixel(input logic fs, input i2dcf_pkg::pix_t px);
        int unsigned w, h, r, c;
        i2dcf_pkg::pix_t colv[KS];
        filt_res_t e;
        w = width_reg;
        h = height_reg;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h == 0)
            h = 1;
        if (fs) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w)
            col_cnt = 0;
        if (row_cnt >= h)
            row_cnt = 0;
        r = row_cnt;
        c = col_cnt;
        for (int i = 0; i < LINES; i++)
            colv[i] = line_mem[((r + 1 + i) % LINES) * MAX_WIDTH + c];
        colv[KS-1] = px;
        for (int i = 0; i < KS; i++) begin
            for (int j = 0; j < KS - 1; j++)
                win_m[i][j] = win_m[i][j+1];
            win_m[i][KS-1] = colv[i];
        end
        line_mem[(r % LINES) * MAX_WIDTH + c] = px;
        if (r >= KS - 1 && c >= KS - 1) begin
            e.r0   = channel_value(0);
            e.r1   = channel_value(1);
            e.r2   = channel_value(2);
            e.row  = POS_W'(r - HALF);
            e.col  = POS_W'(c - HALF);
            e.last = (r == h - 1 && c == w - 1);
            result_q.push_back(e);
        end
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endtask

    // Input driver: accept, then hold, idle or offer the next pixel
    always @(posedge aclk) begin
        pixel_t nx;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                filter_pixel(s_frame_start, {s_pix_ch2, s_pix_ch1, s_pix_ch0});
                n_accepted++;
            end
            if (s_valid && !s_ready) begin
                // hold the offered item
            end else if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                nx = pixel_q.pop_front();
                s_valid       <= 1'b1;
                s_frame_start <= nx.fs;
                s_pix_ch0     <= nx.c0;
                s_pix_ch1     <= nx.c1;
                s_pix_ch2     <= nx.c2;
                src_gap       <= calm ? 0 : $urandom_range(0, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each item against the oldest prediction
    always @(posedge aclk) begin
        filt_res_t e;
        int draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result row %0d col %0d", m_out_row, m_out_col);
                end else begin
                    e = result_q.pop_front();
                    if (e.r0 !== m_res_ch0 || e.r1 !== m_res_ch1 || e.r2 !== m_res_ch2 ||
                        e.row !== m_out_row || e.col !== m_out_col ||
                        e.last !== m_frame_last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("exp %0d %0d %0d r%0d c%0d l%0d got %0d %0d %0d r%0d c%0d l%0d",
                                     e.r0, e.r1, e.r2, e.row, e.col, e.last,
                                     m_res_ch0, m_res_ch1, m_res_ch2,
                                     m_out_row, m_out_col, m_frame_last);
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                draw = calm ? 0 : $urandom_range(0, 9);
                snk_gap <= draw;
                m_ready <= (draw == 0);
            end else if (snk_gap != 0) begin
                snk_gap <= snk_gap - 1;
                m_ready <= (snk_gap == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc++;
        if (cyc > RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Long receiver stall once the random part is under way
    initial begin
        while (n_accepted < 2400)
            @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Let everything drain before touching the registers
    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_valid || result_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input i2dcf_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            i2dcf_pkg::REG_DELTA:  delta_reg = v[DELTA_W-1:0];
            i2dcf_pkg::REG_WIDTH:  width_reg = v[DIM_W-1:0];
            i2dcf_pkg::REG_HEIGHT: height_reg = v[DIM_W-1:0];
            default:               kern_rows[idx] = v;
        endcase
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Same 12-bit coefficient in every tap of all five coefficient rows
    task automatic flat_kernel(input logic [COEF_BITS-1:0] k);
        for (int i = 0; i < NROWS; i++)
            write_reg(i2dcf_pkg::cfg_reg_t'(i), {5{k}});
    endtask

    function automatic logic [COEF_BITS-1:0] rand_coef();
        case ($urandom_range(0, 3))
            0:       return COEF_BITS'($urandom);
            1:       return 12'h7FF;
            default: return COEF_BITS'($urandom_range(0, 160)) - 12'd60;
        endcase
    endfunction

    // Queue a stretch of pixels, frame start on the first and, with noise, now and then on others
    task automatic push_pixels(input int n, input int mode, input bit noise);
        pixel_t p;
        for (int k = 0; k < n; k++) begin
            p.fs = (k == 0) || (noise && $urandom_range(0, 199) == 0);
            case (mode)
                1: begin p.c0 = 8'hFF; p.c1 = 8'hFF; p.c2 = 8'hFF; end
                2: begin p.c0 = '0; p.c1 = 8'hFF; p.c2 = k[0] ? 8'hFF : 8'h00; end
                default: begin
                    p.c0 = $urandom_range(0, 7) == 0 ? 8'hFF : CH_W'($urandom);
                    p.c1 = $urandom_range(0, 7) == 0 ? 8'h00 : CH_W'($urandom);
                    p.c2 = CH_W'($urandom);
                end
            endcase
            pixel_q.push_back(p);
        end
    endtask

    initial begin
        int w, h, sent;
        logic [COEF_BITS-1:0] kr[KS][KS];
        logic [CFG_W-1:0] rowv;
        for (int i = 0; i < NROWS; i++)
            kern_rows[i] = '0;
        delta_reg  = '0;
        width_reg  = DIM_RST;
        height_reg = DIM_RST;
        row_cnt = 0;
        col_cnt = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Default geometry: far too few pixels for a result
        push_pixels(20, 0, 0);
        wait_idle();

        // Largest positive kernel, full pixels, top offset: saturate high
        flat_kernel(12'h7FF);
        write_reg(i2dcf_pkg::REG_DELTA, CFG_W'(255));
        write_reg(i2dcf_pkg::REG_WIDTH, CFG_W'(3));
        write_reg(i2dcf_pkg::REG_HEIGHT, CFG_W'(3));
        push_pixels(9, 1, 0);
        wait_idle();

        // Most negative kernel and bottom offset: saturate low
        flat_kernel(12'h800);
        write_reg(i2dcf_pkg::REG_DELTA, CFG_W'(-255));
        push_pixels(9, 2, 0);
        wait_idle();

        // Identity kernel, no offset, two frames back to back without restart
        flat_kernel(12'h000);
        write_reg(i2dcf_pkg::REG_COEF1, 60'h0000_0000_0100_000);
        write_reg(i2dcf_pkg::REG_DELTA, CFG_W'(0));
        write_reg(i2dcf_pkg::REG_WIDTH, CFG_W'(5));
        write_reg(i2dcf_pkg::REG_HEIGHT, CFG_W'(5));
        push_pixels(50, 0, 0);
        wait_idle();

        // Zero width and height, and a width below the kernel
        write_reg(i2dcf_pkg::REG_WIDTH, CFG_W'(0));
        write_reg(i2dcf_pkg::REG_HEIGHT, CFG_W'(0));
        push_pixels(4, 0, 0);
        wait_idle();
        write_reg(i2dcf_pkg::REG_WIDTH, CFG_W'(2));
        write_reg(i2dcf_pkg::REG_HEIGHT, CFG_W'(4));
        push_pixels(8, 0, 0);
        wait_idle();

        // Oversized width clamps to the line length
        write_reg(i2dcf_pkg::REG_WIDTH, CFG_W'(2047));
        write_reg(i2dcf_pkg::REG_HEIGHT, CFG_W'(3));
        push_pixels(2 * MAX_WIDTH + 4, 0, 0);
        wait_idle();

        // Random frames with random kernels and geometry
        sent = 0;
        while (sent < RAND_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < KS; i++)
                for (int j = 0; j < KS; j++)
                    kr[i][j] = rand_coef();
            for (int i = 0; i < NROWS; i++) begin
                rowv = {$urandom, $urandom};
                if (i < KS)
                    for (int j = 0; j < KS; j++)
                        rowv[COEF_BITS*j +: COEF_BITS] = kr[i][j];
                write_reg(i2dcf_pkg::cfg_reg_t'(i), rowv);
            end
            write_reg(i2dcf_pkg::REG_DELTA, CFG_W'($urandom_range(0, 510) - 255));
            w = $urandom_range(5, 16);
            h = $urandom_range(5, 10);
            write_reg(i2dcf_pkg::REG_WIDTH, CFG_W'(w));
            write_reg(i2dcf_pkg::REG_HEIGHT, CFG_W'(h));
            push_pixels(w * h * $urandom_range(1, 2) + $urandom_range(0, w), 0, 1);
            sent += pixel_q.size();
            wait_idle();
        end

        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/i2dcf_pkg.sv
src/i2dcf_line_ram.sv
src/i2dcf_mac.sv
src/image_2d_correlation_filter.sv
verif/tb_top.sv
